/* hdl/tenu_pkg.sv */
// types, constants and a helper function shared by the text normaliser modules
// no dependencies
`default_nettype none

package tenu_pkg;

	localparam int unsigned WIN_LEN = 12;

	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_LF     = 8'h0a;
	localparam logic [7:0] CH_CR     = 8'h0d;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_HYPHEN = 8'h2d;
	localparam logic [7:0] CH_SHY    = 8'had;
	localparam logic [7:0] BOM_FF    = 8'hff;
	localparam logic [7:0] BOM_FE    = 8'hfe;

	// one result item as it travels to the output
	typedef struct packed {
		logic        has_char;
		logic [15:0] char_value;
		logic        as_escape;
		logic        run_last;
		logic        end_of_text;
	} res_t;

	// one decision taken at the head of the lookahead window
	typedef struct packed {
		logic        has_char;
		logic [15:0] char_value;
		logic        as_escape;
		logic [3:0]  consume;
		logic        nul;
	} dec_t;

	// rules for a decoded value: tab to space, cr dropped, high values escaped
	function automatic res_t decoded(input logic [15:0] v);
		res_t r;
		r = '0;
		if (v == {8'h00, CH_TAB}) begin
			r.has_char   = 1'b1;
			r.char_value = {8'h00, CH_SPACE};
		end else if (v != {8'h00, CH_CR}) begin
			r.has_char   = 1'b1;
			r.char_value = v;
			r.as_escape  = (v >= 16'h0080);
		end
		return r;
	endfunction

endpackage

`default_nettype wire

/* hdl/text_entity_utf_normalizer_top.sv */
// Text normaliser: one text buffer in as a byte stream, normalised characters out.
// A byte is taken in the idle state and worked on in the step state; a byte that
// fills the 12-byte lookahead window is followed by a decision at its head. The
// final byte then drains the window through the single head decision unit at one
// decision per cycle while the result queue is not full, then sends the closing
// item marked end of text. The first two bytes pick utf-16 le/be on a byte order
// mark, else 8-bit mode. A short result queue sits in front of the output, so
// stalls there hold back the input only once it is full.
// depends on tenu_pkg, tenu_front, tenu_queue
`default_nettype none

module text_entity_utf_normalizer_top
	import tenu_pkg::*;
#(
	parameter int unsigned QUEUE_DEPTH = 4
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // byte_in
	input  wire logic        s_tlast,   // final_byte
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [15:0]      m_tdata,   // char_value
	output logic             m_tlast,   // run_last
	output logic [2:0]       m_tuser    // bit 2 end_of_text, bit 1 as_escape, bit 0 has_char
);

	logic push;
	res_t push_item;
	logic q_full;
	res_t head_item;

	tenu_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_byte   (s_tdata),
		.in_final  (s_tlast),
		.push      (push),
		.push_item (push_item),
		.q_full    (q_full)
	);

	tenu_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_item  (push_item),
		.full       (q_full),
		.head_valid (m_tvalid),
		.head_item  (head_item),
		.pop        (m_tready)
	);

	// output item fields
	assign m_tdata = head_item.char_value;
	assign m_tlast = head_item.run_last;
	assign m_tuser = {head_item.end_of_text, head_item.as_escape, head_item.has_char};

endmodule

`default_nettype wire

/* hdl/tenu_decode.sv */
// classifier for the 8-bit lookahead window head: entities, tags, utf-8,
// also nul, tab, cr and soft hyphen; depends on tenu_pkg
`default_nettype none

module tenu_decode
	import tenu_pkg::*;
(
	input  wire logic [WIN_LEN-1:0][7:0] win,
	input  wire logic [3:0]              fill,
	output dec_t                         dec
);

	logic [WIN_LEN-1:0] vld;
	logic [7:0]         ent_ch;
	logic [3:0]         ent_n;
	logic [7:0]         h;
	res_t               u;

	// positions at or past the fill never match
	always_comb begin
		for (int i = 0; i < WIN_LEN; i++) begin
			vld[i] = (4'(i) < fill);
		end
	end

	function automatic logic at(input logic [3:0] i, input logic [7:0] c);
		return vld[i] && (win[i] == c);
	endfunction

	function automatic logic cont(input logic [3:0] i);
		return vld[i] && (win[i][7:6] == 2'b10);
	endfunction

	// entity that starts with an ampersand at the head
	always_comb begin
		ent_ch = "&";
		ent_n  = 4'd1;
		if (at(4'd1, "a")) begin
			if (at(4'd2, "m")) begin
				if (at(4'd3, "p") && at(4'd4, ";")) begin
					ent_ch = "&";
					ent_n  = 4'd5;
					if (at(4'd5, "#") && (at(4'd6, "x") || at(4'd6, "X"))) begin
						if (at(4'd7, "2") && at(4'd8, "0") && at(4'd9, "1")) begin
							if (at(4'd10, "4") && at(4'd11, ";")) begin
								ent_ch = "-";
								ent_n  = 4'd12;
							end else if ((at(4'd10, "c") || at(4'd10, "C") || at(4'd10, "d")
									|| at(4'd10, "D")) && at(4'd11, ";")) begin
								ent_ch = "\"";
								ent_n  = 4'd12;
							end
						end else if (at(4'd7, "2") && at(4'd8, "0") && at(4'd9, "3")) begin
							if ((at(4'd10, "2") || at(4'd10, "3")) && at(4'd11, ";")) begin
								ent_ch = "'";
								ent_n  = 4'd12;
							end
						end else if (at(4'd7, "2") && at(4'd8, "2") && at(4'd9, "1")
								&& at(4'd10, "2") && at(4'd11, ";")) begin
							ent_ch = "-";
							ent_n  = 4'd12;
						end
					end else if (at(4'd5, "a") && at(4'd6, "m") && at(4'd7, "p")
							&& at(4'd8, ";")) begin
						ent_ch = "&";
						ent_n  = 4'd9;
					end else if (at(4'd5, "l") && at(4'd6, "t") && at(4'd7, ";")) begin
						ent_ch = "<";
						ent_n  = 4'd8;
					end else if (at(4'd5, "g") && at(4'd6, "t") && at(4'd7, ";")) begin
						ent_ch = ">";
						ent_n  = 4'd8;
					end
				end
			end else if (at(4'd2, "g") && at(4'd3, "r") && at(4'd4, "a") && at(4'd5, "v")
					&& at(4'd6, "e") && at(4'd7, ";")) begin
				ent_ch = "a";
				ent_n  = 4'd8;
			end
		end else if (at(4'd1, "e") || at(4'd1, "E")) begin
			if ((at(4'd2, "a") && at(4'd3, "c") && at(4'd4, "u") && at(4'd5, "t")
					&& at(4'd6, "e") && at(4'd7, ";"))
					|| (at(4'd2, "g") && at(4'd3, "r") && at(4'd4, "a") && at(4'd5, "v")
					&& at(4'd6, "e") && at(4'd7, ";"))) begin
				ent_ch = win[1];
				ent_n  = 4'd8;
			end
		end else if (at(4'd1, "g") && at(4'd2, "t") && at(4'd3, ";")) begin
			ent_ch = ">";
			ent_n  = 4'd4;
		end else if (at(4'd1, "l") && at(4'd2, "t") && at(4'd3, ";")) begin
			ent_ch = "<";
			ent_n  = 4'd4;
		end else if (at(4'd1, "#") && at(4'd2, "0") && at(4'd3, "3")) begin
			if (at(4'd4, "4") && at(4'd5, ";")) begin
				ent_ch = "\"";
				ent_n  = 4'd6;
			end else if (at(4'd4, "9") && at(4'd5, ";")) begin
				ent_ch = "'";
				ent_n  = 4'd6;
			end
		end
	end

	// utf-8 sequences at the head
	always_comb begin
		h = win[0];
		if ((h[7:4] == 4'he) && cont(4'd1) && cont(4'd2)) begin
			u = decoded({h[3:0], win[1][5:0], win[2][5:0]});
		end else if ((h[7:5] == 3'b110) && cont(4'd1)) begin
			u = decoded({5'b0, h[4:0], win[1][5:0]});
		end else begin
			u = decoded({8'h00, h});
		end
	end

	// one decision for the head byte
	always_comb begin
		dec         = '0;
		dec.consume = 4'd1;
		if (fill == 4'd0) begin
			dec.consume = 4'd0;
		end else if (h == CH_NUL) begin
			dec.nul = 1'b1;
		end else if (h == CH_TAB) begin
			dec.has_char   = 1'b1;
			dec.char_value = {8'h00, CH_SPACE};
		end else if (h == CH_CR) begin
			dec.has_char   = 1'b1;
			dec.char_value = {8'h00, CH_LF};
			dec.consume    = at(4'd1, CH_LF) ? 4'd2 : 4'd1;
		end else if (h == "&") begin
			dec.has_char   = 1'b1;
			dec.char_value = {8'h00, ent_ch};
			dec.consume    = ent_n;
		end else if (h == "<") begin
			dec.has_char = 1'b1;
			if (at(4'd1, "b") && at(4'd2, "r") && at(4'd3, "/") && at(4'd4, ">")) begin
				dec.char_value = {8'h00, CH_SPACE};
				dec.consume    = 4'd5;
			end else begin
				dec.char_value = {8'h00, h};
			end
		end else if (h == CH_SHY) begin
			dec.has_char   = 1'b1;
			dec.char_value = {8'h00, CH_HYPHEN};
		end else if (h[7]) begin
			dec.has_char   = u.has_char;
			dec.char_value = u.char_value;
			dec.as_escape  = u.as_escape;
			if ((h[7:4] == 4'he) && cont(4'd1) && cont(4'd2)) begin
				dec.consume = 4'd3;
			end else if ((h[7:5] == 3'b110) && cont(4'd1)) begin
				dec.consume = 4'd2;
			end
		end else begin
			dec.has_char   = 1'b1;
			dec.char_value = {8'h00, h};
		end
	end

endmodule

`default_nettype wire

/* hdl/tenu_queue.sv */
// short result queue between the decision front and the output side
// depends on tenu_pkg
`default_nettype none

module tenu_queue
	import tenu_pkg::*;
#(
	parameter int unsigned DEPTH = 4
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  res_t      push_item,
	output logic      full,
	output logic      head_valid,
	output res_t      head_item,
	input  wire logic pop
);

	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);

	res_t          store_q [DEPTH];
	logic [PW-1:0] wr_q;
	logic [PW-1:0] rd_q;
	logic [CW-1:0] count_q;
	logic          do_push;
	logic          do_pop;

	// full also counts the item already on its way in, since the front's push
	// is registered and so arrives in the cycle after it checks this flag
	assign full       = (count_q == CW'(DEPTH)) || (push && (count_q == CW'(DEPTH - 1)));
	assign head_valid = (count_q != '0);
	assign head_item  = store_q[rd_q];
	assign do_push    = push && (count_q != CW'(DEPTH));
	assign do_pop     = pop && head_valid;

	// item storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			store_q[wr_q] <= push_item;
		end
	end

	// pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == LAST_PTR) ? '0 : wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= (rd_q == LAST_PTR) ? '0 : rd_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

/* hdl/tenu_front.sv */
// input side: mode choice, lookahead window, code unit assembly and buffer drain
// depends on tenu_pkg and tenu_decode
`default_nettype none

module tenu_front
	import tenu_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [7:0] in_byte,
	input  wire logic       in_final,
	output logic            push,
	output res_t            push_item,
	input  wire logic       q_full
);

	typedef enum logic [1:0] {
		MODE_UNDECIDED,
		MODE_EIGHT,
		MODE_LE,
		MODE_BE
	} mode_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_STEP,
		ST_DEC,
		ST_DRAIN
	} state_t;

	state_t                  state_q;
	mode_t                   mode_q;
	logic [7:0]              byte_q;
	logic                    fin_q;
	logic                    held_q;
	logic [7:0]              hold_q;
	logic [WIN_LEN-1:0][7:0] win_q;
	logic [3:0]              fill_q;
	logic                    nul_q;
	logic [7:0]              half_q;
	logic                    half_pend_q;
	res_t                    pend_q;
	logic                    pend_v_q;

	dec_t                    dec;
	logic [3:0]              take;
	logic [WIN_LEN-1:0][7:0] win_shift;
	logic [15:0]             unit;
	res_t                    unit_res;
	res_t                    dec_res;
	res_t                    dec_end_res;
	res_t                    end_res;

	tenu_decode u_decode (
		.win  (win_q),
		.fill (fill_q),
		.dec  (dec)
	);

	assign in_ready = (state_q == ST_IDLE);

	// window after the head decision consumes its bytes
	always_comb begin
		take = (dec.consume > fill_q) ? fill_q : dec.consume;
		for (int i = 0; i < WIN_LEN; i++) begin
			logic [4:0] src;
			src = 5'(i) + {1'b0, take};
			win_shift[i] = (src < 5'(WIN_LEN)) ? win_q[src[3:0]] : win_q[i];
		end
	end

	// code unit and result views
	always_comb begin
		unit     = (mode_q == MODE_LE) ? {byte_q, half_q} : {half_q, byte_q};
		unit_res = decoded(unit);
		unit_res.run_last = 1'b1;
		dec_res  = '0;
		dec_res.has_char   = dec.has_char;
		dec_res.char_value = dec.char_value;
		dec_res.as_escape  = dec.as_escape;
		dec_end_res          = dec_res;
		dec_end_res.run_last = 1'b1;
		end_res  = pend_v_q ? pend_q : res_t'('0);
		end_res.run_last    = 1'b1;
		end_res.end_of_text = 1'b1;
	end

	// sequencer with its registered outputs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			mode_q      <= MODE_UNDECIDED;
			byte_q      <= '0;
			fin_q       <= 1'b0;
			held_q      <= 1'b0;
			hold_q      <= '0;
			fill_q      <= '0;
			nul_q       <= 1'b0;
			half_q      <= '0;
			half_pend_q <= 1'b0;
			pend_q      <= '0;
			pend_v_q    <= 1'b0;
			push        <= 1'b0;
			push_item   <= '0;
		end else begin
			push <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						byte_q  <= in_byte;
						fin_q   <= in_final;
						state_q <= ST_STEP;
					end
				end
				ST_STEP: begin
					if (!q_full) begin
						state_q <= fin_q ? ST_DRAIN : ST_IDLE;
						case (mode_q)
							MODE_UNDECIDED: begin
								if (!held_q) begin
									if (fin_q) begin
										mode_q   <= MODE_EIGHT;
										win_q[0] <= byte_q;
										fill_q   <= 4'd1;
									end else begin
										held_q <= 1'b1;
										hold_q <= byte_q;
									end
								end else begin
									held_q <= 1'b0;
									if (hold_q == BOM_FF && byte_q == BOM_FE) begin
										mode_q <= MODE_LE;
									end else if (hold_q == BOM_FE && byte_q == BOM_FF) begin
										mode_q <= MODE_BE;
									end else begin
										mode_q   <= MODE_EIGHT;
										win_q[0] <= hold_q;
										win_q[1] <= byte_q;
										fill_q   <= 4'd2;
									end
								end
							end
							MODE_EIGHT: begin
								if (!nul_q && fill_q < 4'(WIN_LEN)) begin
									win_q[fill_q] <= byte_q;
									fill_q        <= fill_q + 4'd1;
									if (!fin_q && fill_q == 4'(WIN_LEN - 1)) begin
										state_q <= ST_DEC;
									end
								end
							end
							default: begin
								if (half_pend_q) begin
									half_pend_q <= 1'b0;
									if (fin_q) begin
										pend_q   <= unit_res;
										pend_v_q <= unit_res.has_char;
									end else begin
										push      <= unit_res.has_char;
										push_item <= unit_res;
									end
								end else begin
									half_q      <= byte_q;
									half_pend_q <= 1'b1;
								end
							end
						endcase
					end
				end
				ST_DEC: begin
					// window just filled: one decision, its result ends the item's run
					if (!q_full) begin
						state_q <= ST_IDLE;
						if (dec.nul) begin
							nul_q  <= 1'b1;
							fill_q <= '0;
						end else begin
							win_q  <= win_shift;
							fill_q <= fill_q - take;
						end
						push      <= dec.has_char;
						push_item <= dec_end_res;
					end
				end
				ST_DRAIN: begin
					if (!q_full) begin
						if (mode_q == MODE_EIGHT && fill_q != '0 && !nul_q) begin
							// one decision a cycle while the queue has room; each result is held in pend_q until the next
							if (dec.nul) begin
								nul_q  <= 1'b1;
								fill_q <= '0;
							end else begin
								win_q  <= win_shift;
								fill_q <= fill_q - take;
							end
							if (dec.has_char) begin
								push      <= pend_v_q;
								push_item <= pend_q;
								pend_q    <= dec_res;
								pend_v_q  <= 1'b1;
							end
						end else begin
							// closing item of the buffer, then back to reset state
							push        <= 1'b1;
							push_item   <= end_res;
							state_q     <= ST_IDLE;
							mode_q      <= MODE_UNDECIDED;
							held_q      <= 1'b0;
							hold_q      <= '0;
							fill_q      <= '0;
							nul_q       <= 1'b0;
							half_q      <= '0;
							half_pend_q <= 1'b0;
							pend_v_q    <= 1'b0;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

/* bench/tb_top.sv */
// testbench for the text normaliser: byte items in, character items out
// self-checking against an in-bench predictor; depends on tenu_pkg and the top level
`timescale 1ns / 1ps
`default_nettype none

module tb_top;
	import tenu_pkg::*;

	typedef enum logic [1:0] {
		TM_UNDECIDED = 2'd0,
		TM_EIGHT     = 2'd1,
		TM_LE        = 2'd2,
		TM_BE        = 2'd3
	} text_mode_e;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} byte_item_t;

	typedef struct packed {
		logic        has_char;
		logic [15:0] char_value;
		logic        as_escape;
		logic        run_last;
		logic        end_of_text;
	} char_item_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;
	logic        s_tlast;
	logic        m_tvalid;
	logic        m_tready;
	logic [15:0] m_tdata;
	logic        m_tlast;
	logic [2:0]  m_tuser;

	text_entity_utf_normalizer_top dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

	// clock
	initial clk = 1'b0;
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	byte_item_t pending_bytes[$];
	char_item_t expected_chars[$];
	int         mismatches;
	int         cycle_count;
	bit         calm;

	// predictor state
	text_mode_e p_mode;
	logic [7:0] p_first;
	bit         p_first_held;
	logic [7:0] p_win [WIN_LEN];
	int         p_fill;
	bit         p_nul;
	logic [7:0] p_half;
	bit         p_half_pend;
	char_item_t step_out[$];

	function automatic void norm_clear();
		p_mode       = TM_UNDECIDED;
		p_first      = '0;
		p_first_held = 0;
		p_fill       = 0;
		p_nul        = 0;
		p_half       = '0;
		p_half_pend  = 0;
		foreach (p_win[i]) p_win[i] = '0;
	endfunction

	function automatic void put_char(bit has, logic [15:0] v, bit esc);
		char_item_t r;
		r = '0;
		r.has_char   = has;
		r.char_value = v;
		r.as_escape  = esc;
		if (step_out.size() < 12) step_out.push_back(r);
	endfunction

	// decoded value rules
	function automatic void put_decoded(logic [15:0] v);
		if (v == 16'h0009) put_char(1, 16'h0020, 0);
		else if (v == 16'h000d) return;
		else put_char(1, v, v >= 16'h0080);
	endfunction

	function automatic bit win_is(int i, logic [7:0] c);
		return i < p_fill && i < WIN_LEN && p_win[i] == c;
	endfunction

	function automatic bit win_str(int start, string s);
		for (int k = 0; k < s.len(); k++)
			if (!win_is(start + k, s[k])) return 0;
		return 1;
	endfunction

	function automatic bit win_cont(int i);
		return i < p_fill && i < WIN_LEN && p_win[i][7:6] == 2'b10;
	endfunction

	function automatic void win_drop(int n);
		if (n > p_fill) n = p_fill;
		for (int i = 0; i < WIN_LEN; i++)
			p_win[i] = (i + n < WIN_LEN) ? p_win[i + n] : p_win[i];
		p_fill -= n;
	endfunction

	// entity match at an ampersand; returns bytes consumed
	function automatic int amp_match(output logic [7:0] ch);
		ch = "&";
		if (win_is(1, "a")) begin
			if (win_is(2, "m")) begin
				if (win_str(3, "p;")) begin
					if (win_is(5, "#") && (win_is(6, "x") || win_is(6, "X"))) begin
						if (win_str(7, "201")) begin
							if (win_str(10, "4;")) begin ch = "-"; return 12; end
							if ((win_is(10, "c") || win_is(10, "C") || win_is(10, "d") ||
								win_is(10, "D")) && win_is(11, ";")) begin
								ch = "\""; return 12;
							end
						end else if (win_str(7, "203")) begin
							if ((win_is(10, "2") || win_is(10, "3")) && win_is(11, ";")) begin
								ch = "'"; return 12;
							end
						end else if (win_str(7, "2212;")) begin
							ch = "-"; return 12;
						end
					end else if (win_str(5, "amp;")) begin ch = "&"; return 9; end
					else if (win_str(5, "lt;")) begin ch = "<"; return 8; end
					else if (win_str(5, "gt;")) begin ch = ">"; return 8; end
					ch = "&";
					return 5;
				end
			end else if (win_str(2, "grave;")) begin ch = "a"; return 8; end
		end else if (win_is(1, "e")) begin
			if (win_str(2, "acute;") || win_str(2, "grave;")) begin ch = "e"; return 8; end
		end else if (win_is(1, "E")) begin
			if (win_str(2, "acute;") || win_str(2, "grave;")) begin ch = "E"; return 8; end
		end else if (win_str(1, "gt;")) begin ch = ">"; return 4; end
		else if (win_str(1, "lt;")) begin ch = "<"; return 4; end
		else if (win_str(1, "#03")) begin
			if (win_str(4, "4;")) begin ch = "\""; return 6; end
			if (win_str(4, "9;")) begin ch = "'"; return 6; end
		end
		ch = "&";
		return 1;
	endfunction

	// one decision at the window head
	function automatic void head_decide();
		logic [7:0]  h;
		logic [7:0]  ch;
		logic [15:0] v;
		int          n;
		if (p_fill == 0) return;
		h = p_win[0];
		if (h == CH_NUL) begin
			p_nul  = 1;
			p_fill = 0;
		end else if (h == CH_TAB) begin
			put_char(1, 16'h0020, 0);
			win_drop(1);
		end else if (h == CH_CR) begin
			put_char(1, 16'h000a, 0);
			win_drop(win_is(1, CH_LF) ? 2 : 1);
		end else if (h == "&") begin
			n = amp_match(ch);
			put_char(1, {8'h00, ch}, 0);
			win_drop(n);
		end else if (h == "<") begin
			if (win_str(1, "br/>")) begin
				put_char(1, 16'h0020, 0);
				win_drop(5);
			end else begin
				put_char(1, 16'h003c, 0);
				win_drop(1);
			end
		end else if (h == CH_SHY) begin
			put_char(1, 16'h002d, 0);
			win_drop(1);
		end else if (h >= 8'h80) begin
			if (h[7:4] == 4'he && win_cont(1) && win_cont(2)) begin
				v = {h[3:0], p_win[1][5:0], p_win[2][5:0]};
				put_decoded(v);
				win_drop(3);
			end else if (h[7:5] == 3'b110 && win_cont(1)) begin
				v = {5'd0, h[4:0], p_win[1][5:0]};
				put_decoded(v);
				win_drop(2);
			end else begin
				put_decoded({8'h00, h});
				win_drop(1);
			end
		end else begin
			put_char(1, {8'h00, h}, 0);
			win_drop(1);
		end
	endfunction

	function automatic void win_push(logic [7:0] b);
		if (p_fill < WIN_LEN) begin
			p_win[p_fill] = b;
			p_fill++;
		end
	endfunction

	// predict the items caused by one accepted byte
	function automatic void predict_byte(byte_item_t it);
		step_out.delete();
		if (p_mode == TM_UNDECIDED) begin
			if (!p_first_held) begin
				if (it.last) begin
					p_mode = TM_EIGHT;
					win_push(it.data);
				end else begin
					p_first_held = 1;
					p_first      = it.data;
				end
			end else begin
				p_first_held = 0;
				if (p_first == BOM_FF && it.data == BOM_FE) p_mode = TM_LE;
				else if (p_first == BOM_FE && it.data == BOM_FF) p_mode = TM_BE;
				else begin
					p_mode = TM_EIGHT;
					win_push(p_first);
					win_push(it.data);
				end
			end
		end else if (p_mode == TM_EIGHT) begin
			if (!p_nul) begin
				win_push(it.data);
				if (!it.last && p_fill == WIN_LEN) head_decide();
			end
		end else if (p_half_pend) begin
			p_half_pend = 0;
			put_decoded(p_mode == TM_LE ? {it.data, p_half} : {p_half, it.data});
		end else begin
			p_half      = it.data;
			p_half_pend = 1;
		end
		if (it.last) begin
			if (p_mode == TM_EIGHT)
				while (p_fill > 0 && !p_nul) head_decide();
			if (step_out.size() == 0) put_char(0, 16'h0000, 0);
			step_out[step_out.size() - 1].end_of_text = 1;
			norm_clear();
		end
		if (step_out.size() > 0) step_out[step_out.size() - 1].run_last = 1;
		foreach (step_out[i]) expected_chars.push_back(step_out[i]);
	endfunction

	// stimulus building
	task automatic add_text(input string s, input bit close);
		byte_item_t it;
		for (int i = 0; i < s.len(); i++) begin
			it.data = s[i];
			it.last = close && (i == s.len() - 1);
			pending_bytes.push_back(it);
		end
	endtask

	task automatic add_byte(input logic [7:0] b, input bit close);
		byte_item_t it;
		it.data = b;
		it.last = close;
		pending_bytes.push_back(it);
	endtask

	function automatic string pick_token();
		string toks[$];
		string s;
		toks = '{"&amp;", "&lt;", "&gt;", "&#034;", "&#039;", "&aacute;", "&agrave;",
			"&eacute;", "&egrave;", "&Eacute;", "&Egrave;", "&amp;amp;", "&amp;lt;",
			"&amp;gt;", "&amp;#x2014;", "&amp;#x201c;", "&amp;#X201D;", "&amp;#x2032;",
			"&amp;#x2033;", "&amp;#x2212;", "<br/>", "<b", "&am", "&amp;#x20", "&#03",
			"\t", "\r", "\r\n", "&", "<"};
		case ($urandom_range(0, 5))
			0, 1: s = toks[$urandom_range(0, toks.size() - 1)];
			2: begin
				s = "   ";
				s[0] = 8'he0 | $urandom_range(0, 15);
				s[1] = 8'h80 | $urandom_range(0, 63);
				s[2] = 8'h80 | $urandom_range(0, 63);
			end
			3: begin
				s = "  ";
				s[0] = 8'hc0 | $urandom_range(0, 31);
				s[1] = 8'h80 | $urandom_range(0, 63);
			end
			4: begin
				s = " ";
				s[0] = $urandom_range(1, 255);
			end
			default: begin
				s = " ";
				s[0] = $urandom_range(8'h20, 8'h7e);
			end
		endcase
		return s;
	endfunction

	task automatic add_random_buffer();
		int kind;
		int n;
		kind = $urandom_range(0, 9);
		if (kind == 0) begin
			add_byte(BOM_FF, 0);
			add_byte(BOM_FE, 0);
			n = $urandom_range(0, 9);
			for (int i = 0; i < n; i++) add_byte($urandom_range(0, 255), 0);
			add_byte($urandom_range(0, 255), 1);
		end else if (kind == 1) begin
			add_byte(BOM_FE, 0);
			add_byte(BOM_FF, 0);
			n = $urandom_range(0, 9);
			for (int i = 0; i < n; i++) add_byte($urandom_range(0, 255), 0);
			add_byte($urandom_range(0, 255), 1);
		end else if (kind == 2) begin
			n = $urandom_range(1, 6);
			for (int i = 0; i < n; i++)
				add_byte($urandom_range(0, 255), i == n - 1);
		end else begin
			n = $urandom_range(2, 8);
			for (int i = 0; i < n; i++) add_text(pick_token(), 0);
			if ($urandom_range(0, 7) == 0) add_byte(CH_NUL, 0);
			add_text(pick_token(), 1);
		end
	endtask

	// driver, idling in random bursts while not calm
	int idle_left;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid  <= 1'b0;
			s_tdata   <= '0;
			s_tlast   <= 1'b0;
			idle_left <= 0;
		end else if (!s_tvalid || s_tready) begin
			if (!calm && idle_left > 0) begin
				s_tvalid  <= 1'b0;
				idle_left <= idle_left - 1;
			end else if (pending_bytes.size() > 0 && (calm || $urandom_range(0, 7) != 0)) begin
				s_tvalid <= 1'b1;
				s_tdata  <= pending_bytes[0].data;
				s_tlast  <= pending_bytes[0].last;
				predict_byte(pending_bytes.pop_front());
			end else begin
				s_tvalid <= 1'b0;
				if (!calm && pending_bytes.size() > 0) idle_left <= $urandom_range(0, 9);
			end
		end
	end

	// receiver stalls in bursts
	int stall_left;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready   <= 1'b0;
			stall_left <= 0;
		end else if (calm) begin
			m_tready <= 1'b1;
		end else if (stall_left > 0) begin
			m_tready   <= 1'b0;
			stall_left <= stall_left - 1;
		end else if ($urandom_range(0, 7) == 0) begin
			m_tready   <= 1'b0;
			stall_left <= $urandom_range(0, 9);
		end else begin
			m_tready <= 1'b1;
		end
	end

	// monitor
	always @(posedge clk) begin
		char_item_t got;
		char_item_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got.has_char    = m_tuser[0];
			got.char_value  = m_tdata;
			got.as_escape   = m_tuser[1];
			got.run_last    = m_tlast;
			got.end_of_text = m_tuser[2];
			if (expected_chars.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected item %h", got);
			end else begin
				want = expected_chars.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display({"mismatch: expected has=%b val=%h esc=%b last=%b eot=%b,",
							" got has=%b val=%h esc=%b last=%b eot=%b"},
							want.has_char, want.char_value, want.as_escape, want.run_last,
							want.end_of_text, got.has_char, got.char_value, got.as_escape,
							got.run_last, got.end_of_text);
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > 200000) begin
			$display("tb: failure");
			$finish;
		end
	end

	initial begin
		string s;
		mismatches  = 0;
		cycle_count = 0;
		calm        = 0;
		norm_clear();
		arst_n = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// directed buffers
		add_byte(8'h41, 1);                            // one-byte buffer
		add_byte(8'h00, 1);                            // lone nul gives empty end item
		add_text("a&amp;&lt;&gt;&#034;&#039;x", 1);
		add_text("&amp;amp;&amp;#x2014;&amp;#x201C;", 1);
		add_text("&amp;#x2033;&amp;#x2212;&eacute;&Egrave;&agrave;", 1);
		add_text("<br/>a<b\tc\r\nd\re&am", 1);
		s = "  x  y z";
		s[0] = 8'had; s[1] = 8'hc3; s[2] = 8'ha9; s[3] = 8'he2; s[4] = 8'h82;
		s[5] = 8'hac; s[6] = 8'hc0; s[7] = 8'h89;    // overlong tab
		add_text(s, 1);
		add_byte(8'hff, 0); add_byte(8'h80, 0); add_byte(8'hc1, 1);
		add_text("ab", 0); add_byte(CH_NUL, 0); add_text("cdef", 1);
		add_byte(BOM_FF, 0); add_byte(BOM_FE, 0); add_byte(8'h09, 0); add_byte(8'h00, 0);
		add_byte(8'h0d, 0); add_byte(8'h00, 0); add_byte(8'hff, 0); add_byte(8'hff, 0);
		add_byte(8'h55, 1);                            // odd trailing byte
		add_byte(BOM_FE, 0); add_byte(BOM_FF, 0); add_byte(8'h00, 0); add_byte(8'h41, 1);
		add_byte(BOM_FF, 0); add_byte(BOM_FE, 1);      // mark only

		while (pending_bytes.size() < 200) add_random_buffer();
		wait (pending_bytes.size() == 0);
		calm = 1;
		repeat (8) add_random_buffer();
		wait (pending_bytes.size() == 0);
		@(posedge clk);
		wait (expected_chars.size() == 0);
		repeat (50) @(posedge clk);
		if (mismatches == 0 && expected_chars.size() == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule

`default_nettype wire
